[rtl/pvpm_pkg.sv]
// Package for the varicode phase modulator: codes, states and lookup tables.
`default_nettype none
package pvpm_pkg;

  // Command codes carried on the cmd field
  localparam logic [1:0] CMD_CHAR  = 2'd0;
  localparam logic [1:0] CMD_IDLE  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam int unsigned SYM_CNT_W   = 6;
  localparam int unsigned WORD_W      = 13;
  localparam logic [SYM_CNT_W-1:0] IDLE_SYMBOLS = 6'd50;
  localparam logic [8:0] PHASE_HALF   = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR,
    ST_REV
  } state_t;

  // Varicode ROM: code bits, right aligned
  localparam logic [9:0] VCODE [128] = '{
    10'd683, 10'd731, 10'd749, 10'd887, 10'd747, 10'd863, 10'd751, 10'd765,
    10'd767, 10'd239, 10'd29,  10'd879, 10'd733, 10'd31,  10'd885, 10'd939,
    10'd759, 10'd757, 10'd941, 10'd943, 10'd859, 10'd875, 10'd877, 10'd855,
    10'd891, 10'd893, 10'd951, 10'd853, 10'd861, 10'd955, 10'd763, 10'd895,
    10'd1,   10'd511, 10'd351, 10'd501, 10'd475, 10'd725, 10'd699, 10'd383,
    10'd251, 10'd247, 10'd367, 10'd479, 10'd117, 10'd53,  10'd87,  10'd431,
    10'd183, 10'd189, 10'd237, 10'd255, 10'd375, 10'd347, 10'd363, 10'd429,
    10'd427, 10'd439, 10'd245, 10'd445, 10'd493, 10'd85,  10'd471, 10'd687,
    10'd701, 10'd125, 10'd235, 10'd173, 10'd181, 10'd119, 10'd219, 10'd253,
    10'd341, 10'd127, 10'd509, 10'd381, 10'd215, 10'd187, 10'd221, 10'd171,
    10'd213, 10'd477, 10'd175, 10'd111, 10'd109, 10'd343, 10'd437, 10'd349,
    10'd373, 10'd379, 10'd685, 10'd503, 10'd495, 10'd507, 10'd703, 10'd365,
    10'd735, 10'd11,  10'd95,  10'd47,  10'd45,  10'd3,   10'd61,  10'd91,
    10'd43,  10'd13,  10'd491, 10'd191, 10'd27,  10'd59,  10'd15,  10'd7,
    10'd63,  10'd447, 10'd21,  10'd23,  10'd5,   10'd55,  10'd123, 10'd107,
    10'd223, 10'd93,  10'd469, 10'd695, 10'd443, 10'd693, 10'd727, 10'd949
  };

  // Varicode ROM: code lengths
  localparam logic [3:0] VLEN [128] = '{
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd8,  4'd5,  4'd10, 4'd10, 4'd5,  4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd1,  4'd9,  4'd9,  4'd9,  4'd9,  4'd10, 4'd10, 4'd9,
    4'd8,  4'd8,  4'd9,  4'd9,  4'd7,  4'd6,  4'd7,  4'd9,
    4'd8,  4'd8,  4'd8,  4'd8,  4'd9,  4'd9,  4'd9,  4'd9,
    4'd9,  4'd9,  4'd8,  4'd9,  4'd9,  4'd7,  4'd9,  4'd10,
    4'd10, 4'd7,  4'd8,  4'd8,  4'd8,  4'd7,  4'd8,  4'd8,
    4'd9,  4'd7,  4'd9,  4'd9,  4'd8,  4'd8,  4'd8,  4'd8,
    4'd8,  4'd9,  4'd8,  4'd7,  4'd7,  4'd9,  4'd9,  4'd9,
    4'd9,  4'd9,  4'd10, 4'd9,  4'd9,  4'd9,  4'd10, 4'd9,
    4'd10, 4'd4,  4'd7,  4'd6,  4'd6,  4'd2,  4'd6,  4'd7,
    4'd6,  4'd4,  4'd9,  4'd8,  4'd5,  4'd6,  4'd4,  4'd3,
    4'd6,  4'd9,  4'd5,  4'd5,  4'd3,  4'd6,  4'd7,  4'd7,
    4'd8,  4'd7,  4'd9,  4'd10, 4'd9,  4'd10, 4'd10, 4'd10
  };

  // Convolution phase steps, indexed by the 5-bit history
  localparam logic [8:0] CONV_STEP [32] = '{
    9'd256, 9'd128, 9'd384, 9'd0,   9'd384, 9'd0,   9'd256, 9'd128,
    9'd0,   9'd384, 9'd128, 9'd256, 9'd128, 9'd256, 9'd0,   9'd384,
    9'd128, 9'd256, 9'd0,   9'd384, 9'd0,   9'd384, 9'd128, 9'd256,
    9'd384, 9'd0,   9'd256, 9'd128, 9'd256, 9'd128, 9'd384, 9'd0
  };

  // Left-aligned symbol word: leading zero, code bits, two trailing zeros
  function automatic logic [WORD_W-1:0] vc_word(input logic [6:0] ch);
    logic [9:0] code;
    logic [3:0] sh;
    code = VCODE[ch];
    sh   = 4'd10 - VLEN[ch];
    return {1'b0, 10'(code << sh), 2'b00};
  endfunction

  // Number of symbols a character produces
  function automatic logic [SYM_CNT_W-1:0] vc_nsym(input logic [6:0] ch);
    return SYM_CNT_W'(VLEN[ch]) + SYM_CNT_W'(3);
  endfunction

endpackage
`default_nettype wire

[rtl/psk31_varicode_phase_modulator_top.sv]
// Varicode BPSK/QPSK phase modulator: command in, one phase beat per symbol out.
//
// Each accepted command item produces its symbols at one per clock while the
// output side takes them: a character gives its varicode length plus three
// symbols (4 to 13), an idle or start command gives 50 reversals. The symbol
// word sits in a 13-bit shift register that moves one bit per cycle while the
// output side takes symbols. Each item is taken in the idle state, before its
// first symbol is produced. in_stall stays high until the final symbol of an
// item has entered the output register, and a command code of 3 is taken in
// the idle state with no output. The mode register is written through the cfg
// port, which is always ready, and must only change while idle.
`default_nettype none
module psk31_varicode_phase_modulator_top
  import pvpm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       qpsk_mode,
  // command input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [6:0] char_code,
  // phase output
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [8:0]      phase_offset,
  output logic            last
);

  state_t               state, state_next;
  logic                 mode;
  logic [WORD_W-1:0]    sreg;
  logic [SYM_CNT_W-1:0] cnt;
  logic [8:0]           carrier_phase, phase_next;
  logic [4:0]           bit_history, hist_next;
  logic                 in_acc;
  logic                 advance;
  logic                 fin;
  logic                 sym_bit;
  logic [8:0]           phase_rev;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign fin       = (cnt == SYM_CNT_W'(1));
  assign sym_bit   = sreg[WORD_W-1];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd == CMD_CHAR) begin
            state_next = ST_CHAR;
          end else if (cmd == CMD_IDLE || cmd == CMD_START) begin
            state_next = ST_REV;
          end
        end
      end
      ST_CHAR, ST_REV: begin
        if (advance && fin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and step enable
  always_comb begin
    in_stall = 1'b1;
    advance  = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_CHAR, ST_REV: advance = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  // Phase for the current symbol
  always_comb begin
    phase_rev = (carrier_phase == 9'd0) ? PHASE_HALF : 9'd0;
    hist_next = bit_history;
    if (state == ST_REV) begin
      phase_next = phase_rev;
    end else if (mode) begin
      hist_next  = {bit_history[3:0], sym_bit};
      phase_next = carrier_phase + CONV_STEP[hist_next];
    end else begin
      phase_next = sym_bit ? carrier_phase : phase_rev;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= 1'b0;
      cnt           <= '0;
      carrier_phase <= '0;
      bit_history   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        mode <= qpsk_mode;
      end
      // load a new item
      if (in_acc) begin
        if (cmd == CMD_CHAR) begin
          cnt <= vc_nsym(char_code);
        end else if (cmd == CMD_IDLE || cmd == CMD_START) begin
          cnt <= IDLE_SYMBOLS;
        end
        if (cmd == CMD_START) begin
          carrier_phase <= '0;
          bit_history   <= '0;
        end
      end
      // advance one symbol
      if (advance) begin
        cnt           <= cnt - SYM_CNT_W'(1);
        carrier_phase <= phase_next;
        bit_history   <= hist_next;
      end
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  // Symbol shift register and output beat
  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_CHAR) begin
      sreg <= vc_word(char_code);
    end else if (advance) begin
      sreg <= {sreg[WORD_W-2:0], 1'b0};
    end
    if (advance) begin
      phase_offset <= phase_next;
      last         <= fin;
    end
  end

endmodule
`default_nettype wire

[rtl/pvpm_checker.sv]
// Port-level checker for the varicode phase modulator, bound to the top level.
`default_nettype none
module pvpm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [8:0] phase_offset,
  input wire logic       last
);

  // Drop any beat on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat survived reset");

  // Hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase_offset) && $stable(last))
    else $error("stalled output beat changed");

  // Keep input stalled while an item still has symbols to come
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken in the middle of an item");

endmodule

bind psk31_varicode_phase_modulator_top pvpm_checker u_pvpm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .phase_offset (phase_offset),
  .last         (last)
);
`default_nettype wire
